FILE: sv/ster_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ster_pkg;

  localparam int unsigned RING_SIZE = 4097;
  localparam int unsigned PTR_W     = $clog2(RING_SIZE);
  localparam int unsigned UC_W      = 16;
  localparam int unsigned CNT_W     = 17;

  typedef logic [PTR_W-1:0] ptr_t;

  localparam ptr_t       RING_LAST = PTR_W'(RING_SIZE - 1);
  localparam logic [7:0] NEWLINE   = 8'h0A;

  localparam logic [1:0] MODE_DATA = 2'd0;
  localparam logic [1:0] MODE_EOI  = 2'd1;
  localparam logic [1:0] MODE_PULL = 2'd2;

  localparam logic [1:0] REG_FROM_END   = 2'd0;
  localparam logic [1:0] REG_BY_LINES   = 2'd1;
  localparam logic [1:0] REG_REVERSE    = 2'd2;
  localparam logic [1:0] REG_UNIT_COUNT = 2'd3;

  localparam logic [2:0] PH_FRESH    = 3'd0;
  localparam logic [2:0] PH_COLLECT  = 3'd1;
  localparam logic [2:0] PH_FWD      = 3'd2;
  localparam logic [2:0] PH_REV_MORE = 3'd3;
  localparam logic [2:0] PH_REV_LAST = 3'd4;
  localparam logic [2:0] PH_DONE     = 3'd5;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_DATA,
    OP_RES_NONE,
    OP_SET_DONE,
    OP_PREV_RD,
    OP_PUT_NL,
    OP_SCAN_INIT,
    OP_SB_STEP,
    OP_SB_UNDER,
    OP_REV_ARM,
    OP_FETCH_INIT,
    OP_REV_UNDER,
    OP_REV_FOUND,
    OP_LN_INC,
    OP_FW_STEP,
    OP_ARM_LINES,
    OP_ARM_BYTES,
    OP_RD_RP,
    OP_PULL
  } dp_op_e;

  typedef struct packed {
    logic            from_end;
    logic            by_lines;
    logic            reverse_lines;
    logic [UC_W-1:0] unit_count;
  } cfg_t;

  typedef struct packed {
    dp_op_e op;
    logic   load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic data_emits;
    logic collecting;
    logic pull_active;
    logic need_fetch;
    logic prev_nl;
    logic sb_under;
    logic hit;
    logic kneg;
    logic k_is_top;
    logic j_lt_n;
  } dp_sts_t;

  function automatic ptr_t slot_after(ptr_t k);
    return (k == RING_LAST) ? '0 : k + PTR_W'(1);
  endfunction

endpackage
`default_nettype wire

FILE: sv/ster_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ster_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data_byte;
  modport source (output valid, output mode, output data_byte, input ready);
  modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface ster_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       final_byte;
  logic       nothing_left;
  modport source (output valid, output out_byte, output final_byte, output nothing_left,
                  input ready);
  modport sink   (input valid, input out_byte, input final_byte, input nothing_left,
                  output ready);
endinterface
`default_nettype wire

FILE: sv/stream_tail_ring_extractor.sv
// Data byte: result staged at the transfer edge, then loaded to the output from S_EMIT once the output is free.
// Pull: RAM read at the transfer edge, staged in S_PULL, then loaded to the output from S_EMIT;
// a reverse-mode line boundary adds a backward scan before the result reaches the output.
// Scans after end of input visit ring bytes through one RAM port: address step, then check.
// Sequential: a new item is taken only in S_IDLE, once the last one and any output stall are done.
// Reset (rst_ni low, async) clears control state; ring contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none
module stream_tail_ring_extractor (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  ster_in_if.sink           in_i,
  ster_out_if.source        out_o,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready
);
  import ster_pkg::*;

  cfg_t    cfg_q;
  dp_cmd_t cmd;
  dp_sts_t sts;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.from_end      <= 1'b1;
      cfg_q.by_lines      <= 1'b1;
      cfg_q.reverse_lines <= 1'b0;
      cfg_q.unit_count    <= UC_W'(10);
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_FROM_END:   cfg_q.from_end      <= pwdata[0];
        REG_BY_LINES:   cfg_q.by_lines      <= pwdata[0];
        REG_REVERSE:    cfg_q.reverse_lines <= pwdata[0];
        REG_UNIT_COUNT: cfg_q.unit_count    <= pwdata[UC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_FROM_END:   prdata = {31'd0, cfg_q.from_end};
      REG_BY_LINES:   prdata = {31'd0, cfg_q.by_lines};
      REG_REVERSE:    prdata = {31'd0, cfg_q.reverse_lines};
      REG_UNIT_COUNT: prdata = {16'd0, cfg_q.unit_count};
      default:        prdata = '0;
    endcase
  end

  ster_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_i.valid),
    .in_mode_i   (in_i.mode),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ster_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .cmd_i          (cmd),
    .data_byte_i    (in_i.data_byte),
    .sts_o          (sts),
    .out_byte_o     (out_o.out_byte),
    .final_byte_o   (out_o.final_byte),
    .nothing_left_o (out_o.nothing_left)
  );

endmodule
`default_nettype wire

FILE: sv/ster_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module ster_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4097
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule
`default_nettype wire

FILE: sv/ster_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module ster_dp (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire ster_pkg::cfg_t    cfg_i,
  input  wire ster_pkg::dp_cmd_t cmd_i,
  input  wire logic [7:0]       data_byte_i,
  output ster_pkg::dp_sts_t      sts_o,
  output logic      [7:0]       out_byte_o,
  output logic                  final_byte_o,
  output logic                  nothing_left_o
);
  import ster_pkg::*;

  ptr_t             wp_q, rp_q, seg_q, mark_q, k_q;
  logic             wrapped_q, kneg_q;
  logic [UC_W-1:0]  skip_q;
  logic [CNT_W-1:0] ll_q, j_q;
  logic [2:0]       phase_q;
  logic [7:0]       res_byte_q;
  logic             res_final_q, res_none_q;

  logic             ram_we;
  ptr_t             ram_addr;
  logic [7:0]       ram_wdata, rdata;

  logic             coll, rev_ph;
  logic [UC_W-1:0]  skip_eff;
  ptr_t             wp_eff, wp_inc, k_dec, start_b, start_l;
  logic [CNT_W-1:0] n_rev, i17, n17;

  ster_ram #(.WIDTH(8), .DEPTH(RING_SIZE)) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (rdata)
  );

  assign coll     = (phase_q == PH_COLLECT);
  assign rev_ph   = (phase_q == PH_REV_MORE) || (phase_q == PH_REV_LAST);
  assign skip_eff = coll ? skip_q :
                    ((cfg_i.unit_count == '0) ? '0 : cfg_i.unit_count - UC_W'(1));
  assign wp_eff   = coll ? wp_q : '0;
  assign wp_inc   = slot_after(wp_eff);
  assign k_dec    = (k_q == '0) ? RING_LAST : k_q - PTR_W'(1);
  assign n_rev    = (cfg_i.unit_count == '0) ? CNT_W'(RING_SIZE) : CNT_W'(cfg_i.unit_count);
  assign i17      = CNT_W'(wp_q);
  assign n17      = CNT_W'(cfg_i.unit_count);
  assign start_l  = kneg_q ? '0 : slot_after(k_q);

  always_comb begin
    if (n17 <= i17) begin
      start_b = PTR_W'(i17 - n17);
    end else if (!wrapped_q) begin
      start_b = '0;
    end else if (n17 >= CNT_W'(RING_SIZE)) begin
      start_b = slot_after(wp_q);
    end else begin
      start_b = PTR_W'(i17 + CNT_W'(RING_SIZE) - n17);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = rp_q;
    ram_wdata = data_byte_i;
    case (cmd_i.op)
      OP_DATA: begin
        ram_we   = 1'b1;
        ram_addr = wp_eff;
      end
      OP_PUT_NL: begin
        ram_we    = 1'b1;
        ram_addr  = wp_q;
        ram_wdata = NEWLINE;
      end
      OP_PREV_RD: ram_addr = (wp_q == '0) ? RING_LAST : wp_q - PTR_W'(1);
      OP_SB_STEP: ram_addr = k_dec;
      OP_FW_STEP: ram_addr = slot_after(k_q);
      default:    ram_addr = rp_q;
    endcase
  end

  always_comb begin
    sts_o.data_emits  = !(cfg_i.from_end || cfg_i.reverse_lines) && (skip_eff == '0);
    sts_o.collecting  = (phase_q == PH_FRESH) || coll;
    sts_o.pull_active = (phase_q == PH_FWD) || rev_ph;
    sts_o.need_fetch  = rev_ph && (rp_q == seg_q) &&
                        !((phase_q == PH_REV_LAST) || (ll_q == '0));
    sts_o.prev_nl     = (wp_q == '0) ? (wrapped_q && (rdata == NEWLINE)) : (rdata == NEWLINE);
    sts_o.sb_under    = (k_q == '0) && !wrapped_q;
    sts_o.hit         = (rdata == NEWLINE) || (k_q == wp_q);
    sts_o.kneg        = kneg_q;
    sts_o.k_is_top    = (k_q == wp_q);
    sts_o.j_lt_n      = (j_q < n17);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      rp_q      <= '0;
      seg_q     <= '0;
      mark_q    <= '0;
      k_q       <= '0;
      wrapped_q <= 1'b0;
      kneg_q    <= 1'b0;
      skip_q    <= '0;
      ll_q      <= '0;
      j_q       <= '0;
      phase_q   <= PH_FRESH;
    end else begin
      case (cmd_i.op)
        OP_DATA: begin
          phase_q   <= PH_COLLECT;
          wp_q      <= wp_inc;
          wrapped_q <= (wp_eff == RING_LAST) ? 1'b1 : (coll && wrapped_q);
          // skip count only moves while bytes are passed from the start
          if (!(cfg_i.from_end || cfg_i.reverse_lines) && (skip_eff != '0) &&
              (!cfg_i.by_lines || (data_byte_i == NEWLINE))) begin
            skip_q <= skip_eff - UC_W'(1);
          end else begin
            skip_q <= skip_eff;
          end
        end
        OP_SET_DONE: phase_q <= PH_DONE;
        OP_PUT_NL: begin
          wp_q <= slot_after(wp_q);
          if (wp_q == RING_LAST) begin
            wrapped_q <= 1'b1;
          end
        end
        OP_SCAN_INIT: begin
          k_q    <= wp_q;
          j_q    <= '0;
          kneg_q <= 1'b0;
        end
        OP_SB_STEP:  k_q    <= k_dec;
        OP_SB_UNDER: kneg_q <= 1'b1;
        OP_REV_ARM: begin
          mark_q <= k_q;
          ll_q   <= n_rev;
        end
        OP_FETCH_INIT: begin
          k_q    <= mark_q;
          kneg_q <= 1'b0;
          seg_q  <= mark_q;
          if (ll_q != '0) begin
            ll_q <= ll_q - CNT_W'(1);
          end
        end
        OP_REV_UNDER: begin
          rp_q    <= '0;
          phase_q <= PH_REV_LAST;
        end
        OP_REV_FOUND: begin
          rp_q    <= slot_after(k_q);
          phase_q <= (k_q == wp_q) ? PH_REV_LAST : PH_REV_MORE;
          mark_q  <= k_q;
        end
        OP_LN_INC:  j_q <= j_q + CNT_W'(1);
        OP_FW_STEP: k_q <= slot_after(k_q);
        OP_ARM_LINES: begin
          if (start_l == wp_q) begin
            phase_q <= PH_DONE;
          end else begin
            rp_q    <= start_l;
            seg_q   <= wp_q;
            phase_q <= PH_FWD;
          end
        end
        OP_ARM_BYTES: begin
          if (start_b == wp_q) begin
            phase_q <= PH_DONE;
          end else begin
            rp_q    <= start_b;
            seg_q   <= wp_q;
            phase_q <= PH_FWD;
          end
        end
        OP_PULL: begin
          if (phase_q == PH_FWD) begin
            rp_q <= slot_after(rp_q);
            if (slot_after(rp_q) == seg_q) begin
              phase_q <= PH_DONE;
            end
          end else if (rp_q == seg_q) begin
            if ((phase_q == PH_REV_LAST) || (ll_q == '0)) begin
              phase_q <= PH_DONE;
            end
          end else begin
            rp_q <= slot_after(rp_q);
          end
        end
        default: ;
      endcase
    end
  end

  // result staging and output register carry payload only
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_DATA: begin
        res_byte_q  <= data_byte_i;
        res_final_q <= 1'b0;
        res_none_q  <= 1'b0;
      end
      OP_RES_NONE: begin
        res_byte_q  <= '0;
        res_final_q <= 1'b0;
        res_none_q  <= 1'b1;
      end
      OP_PULL: begin
        res_byte_q <= rdata;
        res_none_q <= 1'b0;
        if (phase_q == PH_FWD) begin
          res_final_q <= (slot_after(rp_q) == seg_q);
        end else begin
          res_final_q <= (rp_q == seg_q) && ((phase_q == PH_REV_LAST) || (ll_q == '0));
        end
      end
      default: ;
    endcase
    if (cmd_i.load_out) begin
      out_byte_o     <= res_byte_q;
      final_byte_o   <= res_final_q;
      nothing_left_o <= res_none_q;
    end
  end

endmodule
`default_nettype wire

FILE: sv/ster_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ster_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ster_pkg::cfg_t     cfg_i,
  input  wire logic              in_valid_i,
  input  wire logic [1:0]        in_mode_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire ster_pkg::dp_sts_t  sts_i,
  output ster_pkg::dp_cmd_t       cmd_o
);
  import ster_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_EMIT     = 4'd1;
  localparam logic [3:0] S_FIN      = 4'd2;
  localparam logic [3:0] S_REV_PREV = 4'd3;
  localparam logic [3:0] S_REV_SCAN = 4'd4;
  localparam logic [3:0] S_SB_ADDR  = 4'd5;
  localparam logic [3:0] S_SB_CHK   = 4'd6;
  localparam logic [3:0] S_SB_POST  = 4'd7;
  localparam logic [3:0] S_FETCH    = 4'd8;
  localparam logic [3:0] S_FW_ADDR  = 4'd9;
  localparam logic [3:0] S_FW_CHK   = 4'd10;
  localparam logic [3:0] S_PULL     = 4'd11;

  localparam logic [1:0] PU_REV0  = 2'd0;
  localparam logic [1:0] PU_FETCH = 2'd1;
  localparam logic [1:0] PU_LINES = 2'd2;

  logic [3:0] state_q, state_d;
  logic [1:0] pu_q, pu_d;
  logic       emit_q, emit_d;
  logic       ov_q, ov_d;
  logic       acc, out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign acc         = in_valid_i && in_ready_o;
  assign out_free    = !ov_q || out_ready_i;
  assign out_valid_o = ov_q;

  always_comb begin
    state_d      = state_q;
    pu_d         = pu_q;
    emit_d       = emit_q;
    ov_d         = ov_q && !out_ready_i;
    cmd_o.op       = OP_NONE;
    cmd_o.load_out = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          case (in_mode_i)
            MODE_DATA: begin
              cmd_o.op = OP_DATA;
              state_d  = sts_i.data_emits ? S_EMIT : S_IDLE;
            end
            MODE_EOI: begin
              if (sts_i.collecting) begin
                state_d = S_FIN;
              end
            end
            MODE_PULL: begin
              if (sts_i.pull_active) begin
                cmd_o.op = OP_RD_RP;
                state_d  = S_PULL;
              end else begin
                cmd_o.op = OP_RES_NONE;
                state_d  = S_EMIT;
              end
            end
            default: ;
          endcase
        end
      end
      S_PULL: begin
        cmd_o.op = OP_PULL;
        if (sts_i.need_fetch) begin
          emit_d  = 1'b1;
          state_d = S_FETCH;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_FIN: begin
        if (!cfg_i.from_end && !cfg_i.reverse_lines) begin
          cmd_o.op = OP_SET_DONE;
          state_d  = S_IDLE;
        end else if (cfg_i.reverse_lines) begin
          cmd_o.op = OP_PREV_RD;
          state_d  = S_REV_PREV;
        end else if (cfg_i.unit_count == '0) begin
          cmd_o.op = OP_SET_DONE;
          state_d  = S_IDLE;
        end else if (!cfg_i.by_lines) begin
          cmd_o.op = OP_ARM_BYTES;
          state_d  = S_IDLE;
        end else begin
          cmd_o.op = OP_SCAN_INIT;
          pu_d     = PU_LINES;
          state_d  = S_SB_ADDR;
        end
      end
      S_REV_PREV: begin
        // missing trailing newline gets one appended
        if (!sts_i.prev_nl) begin
          cmd_o.op = OP_PUT_NL;
        end
        state_d = S_REV_SCAN;
      end
      S_REV_SCAN: begin
        cmd_o.op = OP_SCAN_INIT;
        pu_d     = PU_REV0;
        emit_d   = 1'b0;
        state_d  = S_SB_ADDR;
      end
      S_FETCH: begin
        cmd_o.op = OP_FETCH_INIT;
        pu_d     = PU_FETCH;
        state_d  = S_SB_ADDR;
      end
      S_SB_ADDR: begin
        if (sts_i.sb_under) begin
          cmd_o.op = OP_SB_UNDER;
          state_d  = S_SB_POST;
        end else begin
          cmd_o.op = OP_SB_STEP;
          state_d  = S_SB_CHK;
        end
      end
      S_SB_CHK: state_d = sts_i.hit ? S_SB_POST : S_SB_ADDR;
      S_SB_POST: begin
        case (pu_q)
          PU_REV0: begin
            if (sts_i.kneg) begin
              cmd_o.op = OP_SET_DONE;
              state_d  = S_IDLE;
            end else begin
              cmd_o.op = OP_REV_ARM;
              state_d  = S_FETCH;
            end
          end
          PU_FETCH: begin
            cmd_o.op = sts_i.kneg ? OP_REV_UNDER : OP_REV_FOUND;
            state_d  = emit_q ? S_EMIT : S_IDLE;
          end
          PU_LINES: begin
            if (!sts_i.kneg && sts_i.j_lt_n && !sts_i.k_is_top) begin
              cmd_o.op = OP_LN_INC;
              state_d  = S_SB_ADDR;
            end else if (!sts_i.kneg && sts_i.k_is_top) begin
              // scan came all the way round: skip to first newline after the oldest slot
              state_d = S_FW_ADDR;
            end else begin
              cmd_o.op = OP_ARM_LINES;
              state_d  = S_IDLE;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_FW_ADDR: begin
        cmd_o.op = OP_FW_STEP;
        state_d  = S_FW_CHK;
      end
      S_FW_CHK: begin
        if (sts_i.hit) begin
          cmd_o.op = OP_ARM_LINES;
          state_d  = S_IDLE;
        end else begin
          state_d = S_FW_ADDR;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          ov_d           = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pu_q    <= PU_REV0;
      emit_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pu_q    <= pu_d;
      emit_q  <= emit_d;
      ov_q    <= ov_d;
    end
  end

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_free) |=> ov_q)
    else $error("staged result not moved to output register");

  a_idle_pull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_mode_i == MODE_PULL && !sts_i.pull_active) |=> (state_q == S_EMIT))
    else $error("idle pull did not produce a result");

  a_late_eoi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_mode_i == MODE_EOI && !sts_i.collecting) |=> (state_q == S_IDLE))
    else $error("end of input after collection was not ignored");

endmodule
`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps
module tb;
  import ster_pkg::*;

  localparam int RS          = RING_SIZE;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int RAND_ITEMS  = 1450;

  typedef struct {
    logic [7:0] ob;
    logic       fin;
    logic       nl;
  } tail_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;

  ster_in_if  in_if ();
  ster_out_if out_if ();

  stream_tail_ring_extractor dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk_i = ~clk_i;

  // ---------------- tail predictor ----------------
  bit          cfg_fe, cfg_bl, cfg_rv;
  logic [15:0] cfg_cnt;
  logic [7:0]  tail_ring [0:RS-1];
  int          wr_pos, rd_pos, seg_end, skip_left, lines_to_go, rev_mark;
  logic [2:0]  tail_ph;
  bit          wrapped;

  tail_res_t pending_q[$];
  int        mismatches = 0;
  int        rand_sent = 0;
  longint    cycles = 0;
  bit        tx_quiet = 1'b0;
  bit        rx_quiet = 1'b0;

  function automatic int next_slot(int k);
    return (k + 1 >= RS) ? 0 : k + 1;
  endfunction

  // walk backward to a newline, or to the oldest slot of a wrapped ring
  function automatic int back_scan(int k);
    forever begin
      k--;
      if (k < 0) begin
        if (!wrapped) return -1;
        k = RS - 1;
      end
      if (tail_ring[k] == NEWLINE || k == wr_pos) return k;
    end
  endfunction

  task automatic rev_fetch();
    int last_k, k;
    last_k = rev_mark;
    k = back_scan(last_k);
    if (k < 0) begin
      rd_pos = 0;
      tail_ph = PH_REV_LAST;
    end else begin
      rd_pos = next_slot(k);
      tail_ph = (k == wr_pos) ? PH_REV_LAST : PH_REV_MORE;
      rev_mark = k;
    end
    seg_end = last_k;
    if (lines_to_go > 0) lines_to_go--;
  endtask

  task automatic end_of_input();
    int n, i, start, k, j;
    bit prev_nl;
    n = cfg_cnt;
    i = wr_pos;
    if (!cfg_fe && !cfg_rv) begin
      tail_ph = PH_DONE;
      return;
    end
    if (cfg_rv) begin
      if (n == 0) n = RS;
      if (i == 0) prev_nl = wrapped && tail_ring[RS-1] == NEWLINE;
      else prev_nl = tail_ring[i-1] == NEWLINE;
      if (!prev_nl) begin
        tail_ring[i] = NEWLINE;
        i++;
        if (i >= RS) begin
          i = 0;
          wrapped = 1'b1;
        end
        wr_pos = i;
      end
      k = back_scan(i);
      if (k < 0) begin
        tail_ph = PH_DONE;
        return;
      end
      rev_mark = k;
      lines_to_go = n;
      rev_fetch();
      return;
    end
    if (n == 0) begin
      tail_ph = PH_DONE;
      return;
    end
    if (!cfg_bl) begin
      if (n <= i) start = i - n;
      else if (!wrapped) start = 0;
      else if (n >= RS) start = next_slot(i);
      else start = i + RS - n;
    end else begin
      k = i;
      j = 0;
      forever begin
        k = back_scan(k);
        if (k < 0) break;
        if (j < n && k != i) j++;
        else break;
      end
      // scan came all the way round: start after first newline past oldest slot
      if (k == i) begin
        do begin
          k++;
          if (k >= RS) k = 0;
        end while (tail_ring[k] != NEWLINE && k != i);
      end
      start = next_slot(k);
    end
    if (start == i) begin
      tail_ph = PH_DONE;
      return;
    end
    rd_pos = start;
    seg_end = i;
    tail_ph = PH_FWD;
  endtask

  task automatic tail_step(input logic [1:0] m, input logic [7:0] b,
                           output bit has, output tail_res_t r);
    has = 1'b0;
    r = '{8'h00, 1'b0, 1'b0};
    if (m == MODE_DATA) begin
      if (tail_ph != PH_COLLECT) begin
        wr_pos = 0;
        wrapped = 1'b0;
        skip_left = (cfg_cnt > 0) ? cfg_cnt - 1 : 0;
        tail_ph = PH_COLLECT;
      end
      tail_ring[wr_pos] = b;
      wr_pos++;
      if (wr_pos >= RS) begin
        wr_pos = 0;
        wrapped = 1'b1;
      end
      if (cfg_fe || cfg_rv) return;
      if (skip_left > 0) begin
        if (!cfg_bl || b == NEWLINE) skip_left--;
        return;
      end
      has = 1'b1;
      r.ob = b;
    end else if (m == MODE_EOI) begin
      if (tail_ph == PH_FRESH || tail_ph == PH_COLLECT) end_of_input();
    end else if (m == MODE_PULL) begin
      has = 1'b1;
      if (tail_ph == PH_FWD) begin
        r.ob = tail_ring[rd_pos];
        rd_pos = next_slot(rd_pos);
        if (rd_pos == seg_end) begin
          r.fin = 1'b1;
          tail_ph = PH_DONE;
        end
      end else if (tail_ph == PH_REV_MORE || tail_ph == PH_REV_LAST) begin
        r.ob = tail_ring[rd_pos];
        if (rd_pos == seg_end) begin
          if (tail_ph == PH_REV_LAST || lines_to_go == 0) begin
            r.fin = 1'b1;
            tail_ph = PH_DONE;
          end else begin
            rev_fetch();
          end
        end else begin
          rd_pos = next_slot(rd_pos);
        end
      end else begin
        r.nl = 1'b1;
      end
    end
  endtask

  // ---------------- drivers ----------------
  task automatic send_item(input logic [1:0] m, input logic [7:0] b, output bit empty);
    int gap;
    bit has;
    tail_res_t r;
    gap = tx_quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.mode      <= m;
    in_if.data_byte <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    tail_step(m, b, has, r);
    if (has) pending_q.push_back(r);
    empty = has && r.nl;
    rand_sent++;
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // a pull always answers, so once it is back no end-of-input scan is running
  task automatic set_cfg(input bit fe, input bit bl, input bit rv, input logic [15:0] cnt);
    bit e;
    send_item(MODE_PULL, 8'h00, e);
    in_if.valid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk_i);
    apb_write(REG_FROM_END, 32'(fe));
    apb_write(REG_BY_LINES, 32'(bl));
    apb_write(REG_REVERSE, 32'(rv));
    apb_write(REG_UNIT_COUNT, 32'(cnt));
    cfg_fe = fe;
    cfg_bl = bl;
    cfg_rv = rv;
    cfg_cnt = cnt;
  endtask

  task automatic send_stream(input int len, input int nl_pct);
    bit e;
    logic [7:0] b;
    for (int n = 0; n < len; n++) begin
      if ($urandom_range(0, 99) < nl_pct) b = NEWLINE;
      else begin
        b = 8'($urandom);
        if (nl_pct == 0 && b == NEWLINE) b = 8'h0B;
      end
      send_item(MODE_DATA, b, e);
    end
  endtask

  task automatic drain_tail();
    bit e;
    send_item(MODE_EOI, 8'h00, e);
    do send_item(MODE_PULL, 8'h00, e); while (!e);
  endtask

  // ---------------- result sink ----------------
  initial begin
    int w;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      w = rx_quiet ? 0 : $urandom_range(0, 19);
      if (w > 0) begin
        out_if.ready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid && out_if.ready));
    end
  end

  always @(posedge clk_i) begin
    tail_res_t x;
    if (out_if.valid && out_if.ready) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: byte %02h", out_if.out_byte);
      end else begin
        x = pending_q.pop_front();
        if (out_if.out_byte !== x.ob || out_if.final_byte !== x.fin
            || out_if.nothing_left !== x.nl) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp byte %02h fin %b empty %b, got %02h %b %b",
                     x.ob, x.fin, x.nl, out_if.out_byte, out_if.final_byte,
                     out_if.nothing_left);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------- tests ----------------
  task automatic test_reverse_empty();
    set_cfg(1'b1, 1'b1, 1'b1, 16'd0);
    drain_tail();
  endtask

  task automatic test_from_start();
    bit e;
    set_cfg(1'b0, 1'b1, 1'b0, 16'd2);
    send_item(MODE_DATA, 8'h00, e);
    send_item(MODE_DATA, NEWLINE, e);
    send_item(MODE_DATA, 8'hFF, e);
    send_item(MODE_PULL, 8'h00, e);
    drain_tail();
    set_cfg(1'b0, 1'b0, 1'b0, 16'd0);
    send_item(MODE_DATA, 8'h55, e);
    send_item(MODE_DATA, 8'hAA, e);
    drain_tail();
  endtask

  task automatic test_from_end();
    bit e;
    set_cfg(1'b1, 1'b1, 1'b0, 16'd1);
    send_item(MODE_DATA, 8'h41, e);
    send_item(MODE_DATA, NEWLINE, e);
    send_item(MODE_DATA, 8'h42, e);
    drain_tail();
    send_item(MODE_EOI, 8'h00, e);  // ignored once done
    send_item(2'd3, 8'h00, e);      // unused mode
    set_cfg(1'b1, 1'b0, 1'b0, 16'd0);
    send_item(MODE_DATA, 8'h43, e);
    drain_tail();
    set_cfg(1'b1, 1'b0, 1'b0, 16'd65535);
    send_item(MODE_DATA, 8'h44, e);
    drain_tail();
  endtask

  task automatic test_reverse();
    set_cfg(1'b1, 1'b1, 1'b1, 16'd2);
    send_stream(12, 30);
    drain_tail();
    set_cfg(1'b0, 1'b0, 1'b1, 16'd65535);
    send_stream(10, 30);
    drain_tail();
  endtask

  task automatic test_wrap();
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    set_cfg(1'b1, 1'b1, 1'b0, 16'd65535);
    send_stream(RS + 150, 3);
    drain_tail();
    set_cfg(1'b1, 1'b1, 1'b0, 16'd3);
    send_stream(RS + 40, 0);
    drain_tail();
    set_cfg(1'b1, 1'b0, 1'b0, 16'd65535);
    send_stream(RS + 60, 5);
    drain_tail();
    set_cfg(1'b1, 1'b0, 1'b0, 16'd5);
    send_stream(RS + 2, 5);
    drain_tail();
    set_cfg(1'b1, 1'b1, 1'b1, 16'd0);
    send_stream(RS + 90, 2);
    drain_tail();
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  task automatic test_random();
    bit e;
    logic [15:0] cnt;
    int len;
    rand_sent = 0;
    while (rand_sent < RAND_ITEMS) begin
      case ($urandom_range(0, 5))
        0: cnt = 16'd0;
        1: cnt = 16'd1;
        2: cnt = 16'd65535;
        default: cnt = 16'($urandom_range(2, 20));
      endcase
      set_cfg($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 3) == 0, cnt);
      tx_quiet = $urandom_range(0, 3) == 0;
      rx_quiet = $urandom_range(0, 3) == 0;
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 9) == 0) send_item(2'd3, 8'($urandom), e);
        if ($urandom_range(0, 9) == 0) send_item(MODE_EOI, 8'h00, e);
        len = $urandom_range(1, 40);
        for (int n = 0; n < len; n++) begin
          send_stream(1, 20);
          if ($urandom_range(0, 19) == 0) send_item(MODE_PULL, 8'h00, e);
          if ($urandom_range(0, 29) == 0) send_item(2'd3, 8'($urandom), e);
        end
        if ($urandom_range(0, 7) == 0) begin
          // partial readout, then a new stream abandons the rest
          send_item(MODE_EOI, 8'h00, e);
          repeat ($urandom_range(1, 4)) send_item(MODE_PULL, 8'h00, e);
        end else begin
          drain_tail();
        end
      end
    end
  endtask

  initial begin
    bit e;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_if.valid <= 1'b0;
    in_if.mode <= MODE_DATA;
    in_if.data_byte <= 8'h00;
    cfg_fe = 1'b1;
    cfg_bl = 1'b1;
    cfg_rv = 1'b0;
    cfg_cnt = 16'd10;
    wr_pos = 0;
    rd_pos = 0;
    seg_end = 0;
    skip_left = 0;
    lines_to_go = 0;
    rev_mark = 0;
    wrapped = 1'b0;
    tail_ph = PH_FRESH;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reverse_empty();
    test_from_start();
    test_from_end();
    test_reverse();
    test_wrap();
    test_random();
    send_item(MODE_PULL, 8'h00, e);
    in_if.valid <= 1'b0;
    wait_drained();
    repeat (100) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
